// File: hw/rtl/mbts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbts_pkg
// Shared types, codes and reset values of the memory bus test sequencer.
// ----------------------------------------------------------------------------
package mbts_pkg;

	localparam int DATA_BITS_DEF = 32;

	// memory under test after reset: 8 MiB of 32-bit words
	localparam int MEM_BYTES_DEF = 8 * 1024 * 1024;
	localparam logic [31:0] MEM_WORDS_RST    = 32'(MEM_BYTES_DEF / 4);
	localparam logic [31:0] TEST_PATTERN_RST = 32'h5555_5555;

	// configuration register indexes
	localparam logic REG_MEM_WORDS    = 1'b0;
	localparam logic REG_TEST_PATTERN = 1'b1;

	// request codes
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_ACK   = 2'd1;
	localparam logic [1:0] REQ_DATA  = 2'd2;

	// command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_DONE  = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] word_offset;
		logic [31:0] write_data;
		logic        data_bus_pass;
		logic        address_bus_pass;
		logic        fill_pass;
	} mbts_res_t;

	function automatic mbts_res_t mk_res(input logic [1:0] cmd, input logic [31:0] off,
			input logic [31:0] data);
		mbts_res_t r;
		r = '0;
		r.cmd         = cmd;
		r.word_offset = off;
		r.write_data  = data;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mbts_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbts_seq
// Test sequencer state and next-access logic; one response word per cycle at most, only while fire is high.
// ----------------------------------------------------------------------------
module mbts_seq
	import mbts_pkg::*;
#(
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] read_data,
	input  wire logic [31:0] mem_words,
	input  wire logic [31:0] test_pattern,
	output logic             res_valid,
	output mbts_res_t        res
);

	typedef enum logic [2:0] {PH_IDLE, PH_DATA, PH_ADDR, PH_FILL, PH_DONE} phase_t;

	// data and fill phases
	localparam logic [2:0] SS_WR = 3'd0;
	localparam logic [2:0] SS_RD = 3'd1;
	// address phase
	localparam logic [2:0] SS_A_WR_POW  = 3'd0;
	localparam logic [2:0] SS_A_WR_ZERO = 3'd1;
	localparam logic [2:0] SS_A_RD_POW  = 3'd2;
	localparam logic [2:0] SS_A_RD_ZERO = 3'd3;
	localparam logic [2:0] SS_A_FAULT   = 3'd4;
	localparam logic [2:0] SS_A_CHECK   = 3'd5;
	localparam logic [2:0] SS_A_RESTORE = 3'd6;

	phase_t               phase_q, ph_d;
	logic [2:0]           sub_q, sub_d;
	logic [DATA_BITS-1:0] walk_q, walk_d, walk_sh;
	logic [31:0]          cur_q, cur_d;
	logic [31:0]          probe_q, probe_d;
	logic [2:0]           flags_q, flags_d;

	logic [31:0] p_first, p_nc, p_np, p_skip_first, p_skip_next, ntp;
	logic [32:0] fill_n;
	logic        fill_more, ack, dat;
	logic        go_addr, go_fill, go_finish;

	// next power-of-two offset below the memory size, zero when none
	function automatic logic [31:0] next_pow(input logic [31:0] p, input logic [31:0] words);
		logic [32:0] n;
		n = {p, 1'b0};
		if (n[32] || n >= {1'b0, words})
			return '0;
		return n[31:0];
	endfunction

	function automatic logic [31:0] skip_probe(input logic [31:0] p, input logic [31:0] probe,
			input logic [31:0] words);
		if (p != '0 && p == probe)
			return next_pow(p, words);
		return p;
	endfunction

	assign p_first      = {31'd0, (mem_words > 32'd1)};
	assign p_nc         = next_pow(cur_q, mem_words);
	assign p_np         = next_pow(probe_q, mem_words);
	assign p_skip_first = skip_probe(p_first, probe_q, mem_words);
	assign p_skip_next  = skip_probe(p_nc, probe_q, mem_words);
	assign ntp          = ~test_pattern;
	assign fill_n       = {1'b0, cur_q} + 33'd1;
	assign fill_more    = fill_n < {1'b0, mem_words};
	assign walk_sh      = walk_q << 1;
	assign ack          = (req_type == REQ_ACK);
	assign dat          = (req_type == REQ_DATA);

	always_comb begin
		ph_d      = phase_q;
		sub_d     = sub_q;
		walk_d    = walk_q;
		cur_d     = cur_q;
		probe_d   = probe_q;
		flags_d   = flags_q;
		res_valid = 1'b0;
		res       = '0;
		go_addr   = 1'b0;
		go_fill   = 1'b0;
		go_finish = 1'b0;
		if (fire) begin
			if (req_type == REQ_START) begin
				ph_d      = PH_DATA;
				sub_d     = SS_WR;
				walk_d    = DATA_BITS'(1);
				cur_d     = '0;
				probe_d   = '0;
				flags_d   = '0;
				res_valid = 1'b1;
				res       = mk_res(CMD_WRITE, 32'd0, 32'd1);
			end else begin
				case (phase_q)
					PH_DATA: begin
						if (sub_q == SS_WR) begin
							if (ack) begin
								sub_d     = SS_RD;
								res_valid = 1'b1;
								res       = mk_res(CMD_READ, 32'd0, 32'd0);
							end
						end else if (dat) begin
							if (read_data != 32'(walk_q)) begin
								go_addr = 1'b1;
							end else if (walk_sh == '0) begin
								walk_d     = walk_sh;
								flags_d[0] = 1'b1;
								go_addr    = 1'b1;
							end else begin
								walk_d    = walk_sh;
								sub_d     = SS_WR;
								res_valid = 1'b1;
								res       = mk_res(CMD_WRITE, 32'd0, 32'(walk_sh));
							end
						end
					end
					PH_ADDR: begin
						case (sub_q)
							SS_A_WR_POW: begin
								if (ack) begin
									res_valid = 1'b1;
									if (p_nc != '0) begin
										cur_d = p_nc;
										res   = mk_res(CMD_WRITE, p_nc, test_pattern);
									end else begin
										sub_d = SS_A_WR_ZERO;
										res   = mk_res(CMD_WRITE, 32'd0, ntp);
									end
								end
							end
							SS_A_WR_ZERO: begin
								if (ack) begin
									res_valid = 1'b1;
									if (p_first != '0) begin
										sub_d = SS_A_RD_POW;
										cur_d = p_first;
										res   = mk_res(CMD_READ, p_first, 32'd0);
									end else begin
										sub_d = SS_A_RD_ZERO;
										res   = mk_res(CMD_READ, 32'd0, 32'd0);
									end
								end
							end
							SS_A_RD_POW: begin
								if (dat) begin
									if (read_data != test_pattern) begin
										go_fill = 1'b1;
									end else begin
										res_valid = 1'b1;
										if (p_nc != '0) begin
											cur_d = p_nc;
											res   = mk_res(CMD_READ, p_nc, 32'd0);
										end else begin
											sub_d = SS_A_RD_ZERO;
											res   = mk_res(CMD_READ, 32'd0, 32'd0);
										end
									end
								end
							end
							SS_A_RD_ZERO: begin
								if (dat) begin
									if (read_data != ntp) begin
										go_fill = 1'b1;
									end else if (p_first == '0) begin
										flags_d[1] = 1'b1;
										go_fill    = 1'b1;
									end else begin
										probe_d   = p_first;
										sub_d     = SS_A_FAULT;
										res_valid = 1'b1;
										res       = mk_res(CMD_WRITE, p_first, ntp);
									end
								end
							end
							SS_A_FAULT: begin
								if (ack) begin
									res_valid = 1'b1;
									if (p_skip_first != '0) begin
										sub_d = SS_A_CHECK;
										cur_d = p_skip_first;
										res   = mk_res(CMD_READ, p_skip_first, 32'd0);
									end else begin
										sub_d = SS_A_RESTORE;
										res   = mk_res(CMD_WRITE, probe_q, test_pattern);
									end
								end
							end
							SS_A_CHECK: begin
								if (dat) begin
									if (read_data != test_pattern) begin
										go_fill = 1'b1;
									end else begin
										res_valid = 1'b1;
										if (p_skip_next != '0) begin
											cur_d = p_skip_next;
											res   = mk_res(CMD_READ, p_skip_next, 32'd0);
										end else begin
											sub_d = SS_A_RESTORE;
											res   = mk_res(CMD_WRITE, probe_q, test_pattern);
										end
									end
								end
							end
							SS_A_RESTORE: begin
								if (ack) begin
									if (p_np == '0) begin
										flags_d[1] = 1'b1;
										go_fill    = 1'b1;
									end else begin
										probe_d   = p_np;
										sub_d     = SS_A_FAULT;
										res_valid = 1'b1;
										res       = mk_res(CMD_WRITE, p_np, ntp);
									end
								end
							end
							default: ;
						endcase
					end
					PH_FILL: begin
						if (sub_q == SS_WR) begin
							if (ack) begin
								res_valid = 1'b1;
								if (fill_more) begin
									cur_d = fill_n[31:0];
									res   = mk_res(CMD_WRITE, fill_n[31:0], fill_n[31:0]);
								end else begin
									sub_d = SS_RD;
									cur_d = '0;
									res   = mk_res(CMD_READ, 32'd0, 32'd0);
								end
							end
						end else if (dat) begin
							if (read_data != cur_q) begin
								go_finish = 1'b1;
							end else if (fill_more) begin
								cur_d     = fill_n[31:0];
								res_valid = 1'b1;
								res       = mk_res(CMD_READ, fill_n[31:0], 32'd0);
							end else begin
								flags_d[2] = 1'b1;
								go_finish  = 1'b1;
							end
						end
					end
					default: ;
				endcase
			end

			// phase entry, in phase order
			if (go_addr) begin
				ph_d      = PH_ADDR;
				res_valid = 1'b1;
				if (p_first != '0) begin
					sub_d = SS_A_WR_POW;
					cur_d = p_first;
					res   = mk_res(CMD_WRITE, p_first, test_pattern);
				end else begin
					sub_d = SS_A_WR_ZERO;
					res   = mk_res(CMD_WRITE, 32'd0, ntp);
				end
			end
			if (go_fill) begin
				ph_d = PH_FILL;
				if (mem_words == '0) begin
					flags_d[2] = 1'b1;
					go_finish  = 1'b1;
				end else begin
					sub_d     = SS_WR;
					cur_d     = '0;
					res_valid = 1'b1;
					res       = mk_res(CMD_WRITE, 32'd0, 32'd0);
				end
			end
			if (go_finish) begin
				ph_d                 = PH_DONE;
				sub_d                = '0;
				res_valid            = 1'b1;
				res                  = mk_res(CMD_DONE, 32'd0, 32'd0);
				res.data_bus_pass    = flags_d[0];
				res.address_bus_pass = flags_d[1];
				res.fill_pass        = flags_d[2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sub_q   <= '0;
			walk_q  <= DATA_BITS'(1);
			cur_q   <= '0;
			probe_q <= '0;
			flags_q <= '0;
		end else begin
			phase_q <= ph_d;
			sub_q   <= sub_d;
			walk_q  <= walk_d;
			cur_q   <= cur_d;
			probe_q <= probe_d;
			flags_q <= flags_d;
		end
	end

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_valid && res.cmd == CMD_DONE) |=> (phase_q == PH_DONE))
		else $error("finished word without entering done phase");

	a_walk_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> $onehot(walk_q))
		else $error("walking value lost its single bit");

	a_addr_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ADDR && (sub_q == SS_A_RD_POW || sub_q == SS_A_CHECK))
		|-> $onehot(cur_q))
		else $error("address phase read offset is not a power of two");

	a_probe_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ADDR && (sub_q == SS_A_FAULT || sub_q == SS_A_CHECK ||
		sub_q == SS_A_RESTORE)) |-> $onehot(probe_q))
		else $error("faulted offset is not a power of two");

endmodule
`default_nettype wire

// File: hw/rtl/mbts_obuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbts_obuf
// Output register with a skid entry; ready upstream comes from a flop.
// ----------------------------------------------------------------------------
module mbts_obuf
	import mbts_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire mbts_res_t push_res,
	output logic           push_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output mbts_res_t      out_res
);

	mbts_res_t out_q, skid_q;
	logic      out_valid_q, skid_valid_q;

	assign push_ready = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_res    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			// output stalled: park the new word
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : push_res;
		end
		if (out_valid_q && !out_ready && push) begin
			skid_q <= push_res;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

endmodule
`default_nettype wire

// File: hw/rtl/memory_bus_test_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// memory_bus_test_sequencer_top
// Memory bus test sequencer: walking ones, address line and index fill tests.
// ----------------------------------------------------------------------------
//  channel  | handshake             | words
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | req_type, read_data
//  out      | out_valid / out_ready | cmd, word_offset, write_data, pass flags
//  cfg      | cfg_wen               | cfg_index, cfg_wdata (write only)
//
//  one word per cycle sustained while out_ready stays high; a word taken on in
//  goes through the input register, then the sequencer into the output register
//  in_ready depends only on flops: it drops when the output skid entry is full
//  reset clears the sequencer to idle and loads the register reset values
// ----------------------------------------------------------------------------
module memory_bus_test_sequencer_top
	import mbts_pkg::*;
#(
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] read_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       cmd,
	output logic [31:0]      word_offset,
	output logic [31:0]      write_data,
	output logic             data_bus_pass,
	output logic             address_bus_pass,
	output logic             fill_pass,
	input  wire logic        cfg_wen,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	logic [31:0] mem_words_q, test_pattern_q;
	logic        valid_s1;
	logic [1:0]  req_type_s1;
	logic [31:0] read_data_s1;
	logic        fire, obuf_ready, res_valid;
	mbts_res_t   res, out_res;

	assign fire     = valid_s1 && obuf_ready;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_words_q    <= MEM_WORDS_RST;
			test_pattern_q <= TEST_PATTERN_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MEM_WORDS:    mem_words_q    <= cfg_wdata;
				REG_TEST_PATTERN: test_pattern_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1  <= req_type;
			read_data_s1 <= read_data;
		end
	end

	mbts_seq #(
		.DATA_BITS(DATA_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.req_type    (req_type_s1),
		.read_data   (read_data_s1),
		.mem_words   (mem_words_q),
		.test_pattern(test_pattern_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	mbts_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.push_ready(obuf_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign cmd              = out_res.cmd;
	assign word_offset      = out_res.word_offset;
	assign write_data       = out_res.write_data;
	assign data_bus_pass    = out_res.data_bus_pass;
	assign address_bus_pass = out_res.address_bus_pass;
	assign fill_pass        = out_res.fill_pass;

endmodule
`default_nettype wire
